>>> design/cm3_pkg.sv
package cm3_pkg;

    // Default fraction bits of the gain format
    localparam int FRAC_BITS_DEF = 12;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int ACC_W    = 32;
    localparam int ROWS     = 3;
    localparam int DEPTH_W  = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd16;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

    // Register map, index = paddr[5:3]
    typedef enum logic [2:0] {
        REG_ROW0_GAINS  = 3'd0,
        REG_ROW1_GAINS  = 3'd1,
        REG_ROW2_GAINS  = 3'd2,
        REG_ROW0_OFFSET = 3'd3,
        REG_ROW1_OFFSET = 3'd4,
        REG_ROW2_OFFSET = 3'd5,
        REG_SRC_BITS    = 3'd6,
        REG_DST_BITS    = 3'd7
    } t_reg_idx;

    // Out-of-range depths saturate to 8..16
    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
        logic [DEPTH_W-1:0] r;
        if (d < DEPTH_MIN) begin
            r = DEPTH_MIN;
        end else if (d > DEPTH_MAX) begin
            r = DEPTH_MAX;
        end else begin
            r = d;
        end
        return r;
    endfunction

endpackage

>>> design/color_matrix_3x3_fixed_point_unit.sv
// 3x3 color matrix, fixed point. Start a request by raising start while busy
// is low; busy never rises, so one pixel can be taken every clock. The three
// components of a pixel appear on o_result_a/b/c with o_valid high for exactly
// one cycle, after the request has passed the pipeline (stages: sample decode,
// gain multiplies, offset accumulate, shift and 16-bit saturate, output clip).
// Results leave in request order and the receiver cannot hold them off, so
// it must take every o_valid cycle. Throughput is one pixel per clock, set by
// the nine 16x16 multipliers working in parallel in the multiply stage.
// Gains, offsets and depths come from the APB port (64-bit data, register i at
// byte address 8*i) and should only be written with no request in flight.
module color_matrix_3x3_fixed_point_unit #(
    parameter int FRAC_BITS = cm3_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_sample_a,
    input  logic [15:0] i_sample_b,
    input  logic [15:0] i_sample_c,
    // result side
    output logic        o_valid,
    output logic [15:0] o_result_a,
    output logic [15:0] o_result_b,
    output logic [15:0] o_result_c,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int SW    = cm3_pkg::SAMPLE_W;
    localparam int GW    = cm3_pkg::GAIN_W;
    localparam int AW    = cm3_pkg::ACC_W;
    localparam int NR    = cm3_pkg::ROWS;
    localparam int DW    = cm3_pkg::DEPTH_W;
    // shift = FRAC_BITS + src - dst, at most FRAC_BITS + 8
    localparam int ShW   = $clog2(FRAC_BITS + 9);
    localparam int LAT   = 5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3*GW-1:0] r_gains  [NR];
    logic [AW-1:0]   r_offset [NR];
    logic [DW-1:0]   r_src_bits;
    logic [DW-1:0]   r_dst_bits;

    logic            cfg_wr;
    cm3_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = cm3_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NR; r++) begin
                r_gains[r]  <= '0;
                r_offset[r] <= '0;
            end
            r_src_bits <= cm3_pkg::DEPTH_MIN;
            r_dst_bits <= cm3_pkg::DEPTH_MIN;
        end else if (cfg_wr) begin
            case (cfg_idx)
                cm3_pkg::REG_ROW0_GAINS:  r_gains[0]  <= pwdata[3*GW-1:0];
                cm3_pkg::REG_ROW1_GAINS:  r_gains[1]  <= pwdata[3*GW-1:0];
                cm3_pkg::REG_ROW2_GAINS:  r_gains[2]  <= pwdata[3*GW-1:0];
                cm3_pkg::REG_ROW0_OFFSET: r_offset[0] <= pwdata[AW-1:0];
                cm3_pkg::REG_ROW1_OFFSET: r_offset[1] <= pwdata[AW-1:0];
                cm3_pkg::REG_ROW2_OFFSET: r_offset[2] <= pwdata[AW-1:0];
                cm3_pkg::REG_SRC_BITS:    r_src_bits  <= pwdata[DW-1:0];
                cm3_pkg::REG_DST_BITS:    r_dst_bits  <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            cm3_pkg::REG_ROW0_GAINS:  prdata = 64'(r_gains[0]);
            cm3_pkg::REG_ROW1_GAINS:  prdata = 64'(r_gains[1]);
            cm3_pkg::REG_ROW2_GAINS:  prdata = 64'(r_gains[2]);
            cm3_pkg::REG_ROW0_OFFSET: prdata = 64'(r_offset[0]);
            cm3_pkg::REG_ROW1_OFFSET: prdata = 64'(r_offset[1]);
            cm3_pkg::REG_ROW2_OFFSET: prdata = 64'(r_offset[2]);
            cm3_pkg::REG_SRC_BITS:    prdata = 64'(r_src_bits);
            cm3_pkg::REG_DST_BITS:    prdata = 64'(r_dst_bits);
            default:                  prdata = '0;
        endcase
    end

    // effective depths, shift: user must keep static while requests in flight
    logic [DW-1:0]  src_d;
    logic [DW-1:0]  dst_d;
    logic [ShW-1:0] shamt;
    logic [SW-1:0]  smask;
    logic [SW-1:0]  dmax;

    assign src_d = cm3_pkg::clamp_depth(r_src_bits);
    assign dst_d = cm3_pkg::clamp_depth(r_dst_bits);
    assign shamt = ShW'(FRAC_BITS) + ShW'(src_d) - ShW'(dst_d);
    assign smask = SW'((17'(1) << src_d) - 17'(1));
    assign dmax  = SW'((17'(1) << dst_d) - 17'(1));

    // ------------------------------------------------------------------
    // Pipeline; valid bits travel alongside, no stall on either side
    // ------------------------------------------------------------------
    logic             accept;
    logic [LAT-1:0]   r_vld;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // Stage 1: samples to signed 16 (flip at 16-bit depth, else mask)
    logic [SW-1:0]        raw [NR];
    logic signed [SW-1:0] n_smp [NR];
    logic signed [SW-1:0] r_smp [NR];

    assign raw[0] = i_sample_a;
    assign raw[1] = i_sample_b;
    assign raw[2] = i_sample_c;

    always_comb begin
        for (int k = 0; k < NR; k++) begin
            if (src_d == cm3_pkg::DEPTH_MAX) begin
                n_smp[k] = $signed(raw[k] ^ cm3_pkg::SIGN_FLIP);
            end else begin
                n_smp[k] = $signed(raw[k] & smask);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NR; k++) begin
            r_smp[k] <= n_smp[k];
        end
    end

    // Stage 2: nine gain x sample products
    logic signed [AW-1:0] r_prod [NR][NR];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NR; r++) begin
            for (int k = 0; k < NR; k++) begin
                r_prod[r][k] <= AW'($signed(r_gains[r][k*GW +: GW])) * AW'(r_smp[k]);
            end
        end
    end

    // Stage 3: offset plus products, 32-bit wrap
    logic [AW-1:0] r_acc [NR];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NR; r++) begin
            r_acc[r] <= r_offset[r] + AW'(r_prod[r][0]) + AW'(r_prod[r][1])
                      + AW'(r_prod[r][2]);
        end
    end

    // Stage 4: arithmetic shift, saturate to signed 16
    logic signed [AW-1:0] shifted [NR];
    logic signed [SW-1:0] n_sat [NR];
    logic signed [SW-1:0] r_sat [NR];

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            shifted[r] = $signed(r_acc[r]) >>> shamt;
            if (shifted[r] > 32'sd32767) begin
                n_sat[r] = 16'sh7fff;
            end else if (shifted[r] < -32'sd32768) begin
                n_sat[r] = -16'sh8000;
            end else begin
                n_sat[r] = shifted[r][SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NR; r++) begin
            r_sat[r] <= n_sat[r];
        end
    end

    // Stage 5: flip back at 16-bit depth, else clip to 0..2^dst-1
    logic [SW-1:0] n_res [NR];
    logic [SW-1:0] r_res [NR];

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            if (dst_d == cm3_pkg::DEPTH_MAX) begin
                n_res[r] = r_sat[r] ^ cm3_pkg::SIGN_FLIP;
            end else if (r_sat[r] < 0) begin
                n_res[r] = '0;
            end else if (r_sat[r] > $signed(dmax)) begin
                n_res[r] = dmax;
            end else begin
                n_res[r] = r_sat[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NR; r++) begin
            r_res[r] <= n_res[r];
        end
    end

    assign o_valid    = r_vld[LAT-1];
    assign o_result_a = r_res[0];
    assign o_result_b = r_res[1];
    assign o_result_c = r_res[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LAT))
        else $error("result strobe without a request taken %0d cycles earlier", LAT);

    a_request_gets_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("request taken but no result strobe after %0d cycles", LAT);

    a_one_in_flight_per_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == $countones($past(r_vld[LAT-2:0])) + 32'($past(accept)))
        else $error("pipeline valid bits lost or duplicated a request");

endmodule

>>> tb/cm3_pixel_checker.sv
module cm3_pixel_checker #(
    parameter int FRAC_BITS = cm3_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] i_sample_a,
    input  logic [15:0] i_sample_b,
    input  logic [15:0] i_sample_c,
    input  logic        o_valid,
    input  logic [15:0] o_result_a,
    input  logic [15:0] o_result_b,
    input  logic [15:0] o_result_c,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          outstanding,
    output int          results_checked
);

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_pixel;

    // shadow copy of the register file
    logic [47:0] gains_q [cm3_pkg::ROWS];
    logic [31:0] offset_q [cm3_pkg::ROWS];
    logic [4:0]  src_q;
    logic [4:0]  dst_q;

    t_pixel converted_q[$];
    t_pixel want;
    int     mismatches = 0;
    int     compared = 0;

    assign mismatch_count  = mismatches;
    assign results_checked = compared;

    function automatic int depth_of(input logic [4:0] d);
        if (d < cm3_pkg::DEPTH_MIN) return int'(cm3_pkg::DEPTH_MIN);
        if (d > cm3_pkg::DEPTH_MAX) return int'(cm3_pkg::DEPTH_MAX);
        return int'(d);
    endfunction

    // unsigned sample -> signed working value
    function automatic int sample_value(input logic [15:0] raw, input int sb);
        if (sb == 16) return int'($signed(raw ^ cm3_pkg::SIGN_FLIP));
        return int'(raw & 16'((1 << sb) - 1));
    endfunction

    function automatic logic [15:0] mix_row(input logic [47:0] g, input logic [31:0] ofs,
                                            input int s0, input int s1, input int s2,
                                            input int sb, input int db);
        logic [31:0]        acc;
        logic signed [31:0] shifted;
        int                 v;
        int                 ceiling;
        acc = ofs + 32'(int'($signed(g[15:0])) * s0)
                  + 32'(int'($signed(g[31:16])) * s1)
                  + 32'(int'($signed(g[47:32])) * s2);
        shifted = $signed(acc) >>> (FRAC_BITS + sb - db);
        if (shifted < -32768) v = -32768;
        else if (shifted > 32767) v = 32767;
        else v = int'(shifted);
        if (db == 16) return 16'(v) ^ cm3_pkg::SIGN_FLIP;
        ceiling = (1 << db) - 1;
        if (v < 0) v = 0;
        if (v > ceiling) v = ceiling;
        return 16'(v);
    endfunction

    function automatic t_pixel convert_pixel(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] c);
        t_pixel p;
        int     sb;
        int     db;
        int     sa;
        int     sbv;
        int     sc;
        sb  = depth_of(src_q);
        db  = depth_of(dst_q);
        sa  = sample_value(a, sb);
        sbv = sample_value(b, sb);
        sc  = sample_value(c, sb);
        p.a = mix_row(gains_q[0], offset_q[0], sa, sbv, sc, sb, db);
        p.b = mix_row(gains_q[1], offset_q[1], sa, sbv, sc, sb, db);
        p.c = mix_row(gains_q[2], offset_q[2], sa, sbv, sc, sb, db);
        return p;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < cm3_pkg::ROWS; r++) begin
                gains_q[r]  = '0;
                offset_q[r] = '0;
            end
            src_q = 5'd8;
            dst_q = 5'd8;
            converted_q.delete();
        end else begin
            if (o_valid) begin
                if (converted_q.size() == 0) begin
                    $error("result with no request waiting: a=%h b=%h c=%h",
                           o_result_a, o_result_b, o_result_c);
                    mismatches++;
                end else begin
                    want = converted_q.pop_front();
                    check_field("result_a", want.a, o_result_a);
                    check_field("result_b", want.b, o_result_b);
                    check_field("result_c", want.c, o_result_c);
                    compared++;
                end
            end
            if (start && !busy)
                converted_q.push_back(convert_pixel(i_sample_a, i_sample_b, i_sample_c));
            if (psel && penable && pwrite && pready) begin
                case (cm3_pkg::t_reg_idx'(paddr[5:3]))
                    cm3_pkg::REG_ROW0_GAINS:  gains_q[0]  = pwdata[47:0];
                    cm3_pkg::REG_ROW1_GAINS:  gains_q[1]  = pwdata[47:0];
                    cm3_pkg::REG_ROW2_GAINS:  gains_q[2]  = pwdata[47:0];
                    cm3_pkg::REG_ROW0_OFFSET: offset_q[0] = pwdata[31:0];
                    cm3_pkg::REG_ROW1_OFFSET: offset_q[1] = pwdata[31:0];
                    cm3_pkg::REG_ROW2_OFFSET: offset_q[2] = pwdata[31:0];
                    cm3_pkg::REG_SRC_BITS:    src_q       = pwdata[4:0];
                    cm3_pkg::REG_DST_BITS:    dst_q       = pwdata[4:0];
                    default: ;
                endcase
            end
        end
        outstanding = converted_q.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;

    localparam int FRAC         = cm3_pkg::FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 8;
    // pipeline depth of the unit, plus nothing: every request yields a result
    localparam int LATENCY      = 5;
    // run limit; keep a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic [15:0] i_sample_a = '0;
    logic [15:0] i_sample_b = '0;
    logic [15:0] i_sample_c = '0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [5:0]  paddr      = '0;
    logic [63:0] pwdata     = '0;

    wire         busy;
    wire         o_valid;
    wire  [15:0] o_result_a;
    wire  [15:0] o_result_b;
    wire  [15:0] o_result_c;
    wire  [63:0] prdata;
    wire         pready;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int requests_sent   = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;
    int src_depth       = 8;   // effective input depth, steers corner samples

    color_matrix_3x3_fixed_point_unit #(.FRAC_BITS(FRAC)) uut (
        .i_clk, .i_rst_n,
        .start, .busy,
        .i_sample_a, .i_sample_b, .i_sample_c,
        .o_valid, .o_result_a, .o_result_b, .o_result_c,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // watches both channels and the APB port, predicts and compares
    cm3_pixel_checker #(.FRAC_BITS(FRAC)) pixel_checker (
        .i_clk, .i_rst_n,
        .start, .busy,
        .i_sample_a, .i_sample_b, .i_sample_c,
        .o_valid, .o_result_a, .o_result_b, .o_result_c,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .mismatch_count, .outstanding, .results_checked
    );

    always #1 i_clk = ~i_clk;

    // hard stop if the pipeline hangs or results go missing
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // One APB write: setup cycle, then access until pready. psel is left high
    // so writes can run back to back; load_matrix drops it at the end.
    task automatic apb_write(input cm3_pkg::t_reg_idx idx, input logic [63:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        penable <= 1'b0;
    endtask

    // Writes the whole register file. Only called with the pipeline empty.
    task automatic load_matrix(input logic [63:0] g0, input logic [63:0] g1,
                               input logic [63:0] g2, input logic [31:0] o0,
                               input logic [31:0] o1, input logic [31:0] o2,
                               input logic [4:0] sb, input logic [4:0] db);
        apb_write(cm3_pkg::REG_ROW0_GAINS, g0);
        apb_write(cm3_pkg::REG_ROW1_GAINS, g1);
        apb_write(cm3_pkg::REG_ROW2_GAINS, g2);
        apb_write(cm3_pkg::REG_ROW0_OFFSET, {32'($urandom), o0});  // upper half is don't-care
        apb_write(cm3_pkg::REG_ROW1_OFFSET, {32'($urandom), o1});
        apb_write(cm3_pkg::REG_ROW2_OFFSET, {32'($urandom), o2});
        apb_write(cm3_pkg::REG_SRC_BITS, {59'($urandom), sb});
        apb_write(cm3_pkg::REG_DST_BITS, {59'($urandom), db});
        psel   <= 1'b0;
        pwrite <= 1'b0;
        src_depth = int'(cm3_pkg::clamp_depth(sb));
        settings_loaded++;
    endtask

    // Hold a request until the unit takes it. Returns on the accepting edge
    // with start still high, so the caller may chain the next request.
    task automatic send_pixel(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
        start      <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending until every outstanding result is back, then let the
    // pipeline settle before touching registers.
    task automatic drain_requests();
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Mostly full-range noise (upper bits get masked below 16-bit depth),
    // with a sprinkling of corner samples.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cm3_pkg::SIGN_FLIP;
            3:       return 16'((1 << src_depth) - 1);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // New matrix per phase. First phases pin the depth extremes; later ones
    // draw depths at random, out-of-range codes included. Tame gains keep
    // most outputs inside the clip window, wild ones hit saturation and
    // accumulator wrap-around.
    task automatic random_setting(input int phase);
        logic [4:0]  sb;
        logic [4:0]  db;
        logic [63:0] g [3];
        logic [31:0] o [3];
        int          sh;
        bit          tame;
        case (phase)
            0: begin sb = 5'd8;  db = 5'd8;  end
            1: begin sb = 5'd16; db = 5'd16; end
            2: begin sb = 5'd8;  db = 5'd16; end
            3: begin sb = 5'd16; db = 5'd8;  end
            default: begin
                sb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(8, 16));
                db = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(8, 16));
            end
        endcase
        tame = (phase % 3) != 2;
        sh   = FRAC + int'(cm3_pkg::clamp_depth(sb)) - int'(cm3_pkg::clamp_depth(db));
        for (int r = 0; r < 3; r++) begin
            if (tame) begin
                for (int k = 0; k < 3; k++)
                    g[r][16*k +: 16] = 16'(int'($urandom_range(0, 2 << FRAC)) - (1 << FRAC));
                g[r][63:48] = 16'($urandom);
                // rounding half-LSB plus a small offset in output units
                o[r] = 32'((1 << (sh - 1)) + ((int'($urandom_range(0, 64)) - 32) <<< sh));
            end else begin
                g[r] = {32'($urandom), 32'($urandom)};
                o[r] = 32'($urandom);
            end
        end
        load_matrix(g[0], g[1], g[2], o[0], o[1], o[2], sb, db);
    endtask

    initial begin
        int in_phase;
        int burst;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset matrix: all gains zero, 8-bit in and out
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_requests();

        // 16-bit both sides: full-scale gains, offsets at both ends of the
        // accumulator range so the sum wraps, sign flip in and out
        load_matrix({3{16'h7FFF}}, {3{16'h8000}}, 48'h1000_0000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 5'd16, 5'd16);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h7FFF, 16'h8000, 16'hFFFF);
        send_pixel(16'h1234, 16'hABCD, 16'h5A5A);
        drain_requests();

        // identity with rounding; depth codes below 8 and above 16 saturate,
        // junk above the 8-bit sample must be masked
        load_matrix(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000,
                    32'd8, 32'd8, 32'd8, 5'd0, 5'd31);
        send_pixel(16'h00FF, 16'hFF00, 16'hFFFF);
        send_pixel(16'h0080, 16'h7F01, 16'hA55A);
        send_pixel(16'h0000, 16'h0001, 16'hFF7F);
        drain_requests();

        // 16-bit in, 8-bit out: negative sums clip to zero, large ones to max
        load_matrix(48'h0000_0000_F000, {3{16'h7FFF}}, 48'h8000_7FFF_1000,
                    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5'd31, 5'd3);
        send_pixel(16'hFFFF, 16'h0000, 16'h8000);
        send_pixel(16'h0000, 16'hFFFF, 16'h7FFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'h4000, 16'hC000, 16'h0001);
        drain_requests();

        // 8-bit in, 16-bit out with mixed gains; then odd in-between depths
        load_matrix(48'h0800_F800_1000, 48'hFFFF_0001_8000, 48'h7FFF_7FFF_7FFF,
                    32'hFFFF_FFF8, 32'h0000_0008, 32'h0001_0000, 5'd8, 5'd16);
        send_pixel(16'h00FF, 16'h0000, 16'h0080);
        send_pixel(16'h0000, 16'h00FF, 16'h00FF);
        drain_requests();
        load_matrix(48'h0400_0800_0C00, 48'hFC00_0800_0400, 48'h0000_F000_2000,
                    32'd1024, 32'd1024, 32'hFFFF_0000, 5'd12, 5'd10);
        send_pixel(16'h0FFF, 16'h0FFF, 16'h0FFF);
        send_pixel(16'hF800, 16'h0123, 16'h0ABC);
        drain_requests();

        // --- random: bursts of requests with random gaps, a fresh matrix
        // per phase, occasional full drains mid-phase ---
        for (int phase = 0; phase < PHASES; phase++) begin
            random_setting(phase);
            in_phase = 0;
            while (in_phase < RANDOM_ITEMS / PHASES) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 20);
                for (int i = 0; i < burst && in_phase < RANDOM_ITEMS / PHASES; i++) begin
                    send_pixel(pick_sample(), pick_sample(), pick_sample());
                    in_phase++;
                end
                case ($urandom_range(0, 9))
                    0:          drain_requests();
                    1, 2, 3, 4,
                    5, 6:       pause($urandom_range(1, 6));
                    default: ;  // next burst follows back to back
                endcase
            end
            drain_requests();
        end

        // drain_requests already waited for the queue to empty plus latency
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("Covered %0d pixel requests, %0d results compared, over %0d matrix settings",
                 requests_sent, results_checked, settings_loaded);
        $display("(8/16-bit and clamped depths, sign-flip paths, saturation and wrap-around).");
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
